// ===== hdl/mwc_pkg.sv =====
package mwc_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int TOP_WIDTH       = 32;
   localparam int AMOUNT_WIDTH    = 32;
   localparam int KIND_WIDTH      = 2;
   localparam int RESULT_WIDTH    = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_ADD  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SUB  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_LOAD,
      OP_KEEP
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [AMOUNT_WIDTH-1:0] amount;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } link_type;

endpackage

// ===== hdl/modular_wrap_counter.sv =====
// Modular up/down counter: keeps a count in 0..top_value and, for every word taken on the
// req_ side, adds, subtracts or loads the amount reduced modulo top_value+1 (an unknown kind
// keeps the count), returning the new count as one word on the rsp_ side. Words are queued two
// deep ahead of the execution unit, and a finished result waits in an output register
// while the next word is already being worked on. Each word is picked up, its amount is
// reduced by the remainder unit, which retires one bit per cycle, and the result is
// applied once the output register is free; the first word after a top_value write also
// reduces the stored count. With top_value all ones no remainder is needed. Reload the
// count after changing top_value.
module modular_wrap_counter import mwc_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [KIND_WIDTH-1:0]   req_tuser,   // [1:0] kind
   input  logic [AMOUNT_WIDTH-1:0] req_tdata,   // [31:0] amount
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RESULT_WIDTH-1:0] rsp_tdata,   // [31:0] count_out
   input  logic                    csr_wr_en,
   input  logic [TOP_WIDTH-1:0]    csr_wr_data  // top_value
);

   job_type  push_job;
   logic     push_valid, push_ready, pop;
   link_type pop_link;

   mwc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_job   (push_job),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   mwc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_link   (pop_link),
      .pop        (pop)
   );

   mwc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_link    (pop_link),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== hdl/mwc_front.sv =====
module mwc_front import mwc_pkg::*; (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [KIND_WIDTH-1:0]   req_tuser,   // kind
   input  logic [AMOUNT_WIDTH-1:0] req_tdata,   // amount
   output job_type                 push_job,
   output logic                    push_valid,
   input  logic                    push_ready
);

   op_type op;

   always_comb begin
      unique case (req_tuser)
         KIND_ADD:  op = OP_ADD;
         KIND_SUB:  op = OP_SUB;
         KIND_LOAD: op = OP_LOAD;
         default:   op = OP_KEEP;
      endcase
   end

   assign push_job   = '{op: op, amount: req_tdata};
   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== hdl/mwc_queue.sv =====
module mwc_queue import mwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   output link_type pop_link,
   input  logic    pop
);

   localparam int PTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_WIDTH = $clog2(QUEUE_DEPTH + 1);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_WIDTH-1:0]  fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_ready = (fill_ff != FILL_WIDTH'(QUEUE_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (fill_ff != '0);

   assign pop_link.valid = (fill_ff != '0);
   assign pop_link.job   = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] p);
      ptr_next = (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/mwc_rem.sv =====
module mwc_rem #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]     dvd_ff, dvd_in;
   logic [WIDTH-1:0]     div_ff, div_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WIDTH:0]       trial;
   logic                 busy;

   assign busy  = (cnt_ff != '0);
   assign trial = {rem_ff, dvd_ff[WIDTH-1]};

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = busy && (cnt_ff == CNT_WIDTH'(1));
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         div_in = divisor;
         cnt_in = CNT_WIDTH'(WIDTH);
      end else if (busy) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/mwc_back.sv =====
module mwc_back import mwc_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [TOP_WIDTH-1:0]    csr_wr_data,
   input  link_type                pop_link,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RESULT_WIDTH-1:0] rsp_tdata
);

   localparam int W = COUNT_WIDTH;

   localparam logic [1:0] STATE_IDLE  = 2'd0;
   localparam logic [1:0] STATE_AMT   = 2'd1;
   localparam logic [1:0] STATE_CNT   = 2'd2;
   localparam logic [1:0] STATE_APPLY = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [TOP_WIDTH-1:0]    top_ff, top_in;
   logic                    dirty_ff, dirty_in;
   op_type                  op_ff, op_in;
   logic [W-1:0]            count_ff, count_in;
   logic [W-1:0]            r_ff, r_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [W-1:0] top_w, amt_w, modulus, new_count, add_res, sub_res;
   logic [W:0]   sum, modulus_x;
   logic         full_mod, out_free;
   logic         rem_start, rem_done;
   logic [W-1:0] rem_value, rem_result;

   assign top_w     = W'(top_ff);
   assign full_mod  = &top_w;
   assign modulus   = top_w + 1'b1;
   assign modulus_x = {1'b0, top_w} + 1'b1;
   assign amt_w     = W'(pop_link.job.amount);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   mwc_rem #(.WIDTH(W)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_value),
      .divisor   (modulus),
      .done      (rem_done),
      .remainder (rem_result)
   );

   // wrap add / subtract inside 0..top
   assign sum     = {1'b0, count_ff} + {1'b0, r_ff};
   assign add_res = (sum > {1'b0, top_w}) ? W'(sum - modulus_x) : W'(sum);
   assign sub_res = count_ff - r_ff + ((r_ff > count_ff) ? modulus : '0);

   always_comb begin
      case (op_ff)
         OP_ADD:  new_count = add_res;
         OP_SUB:  new_count = sub_res;
         OP_LOAD: new_count = r_ff;
         default: new_count = count_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      dirty_in     = dirty_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      rem_start    = 1'b0;
      rem_value    = amt_w;

      unique case (state_ff)
         STATE_IDLE: begin
            if (pop_link.valid) begin
               pop   = 1'b1;
               op_in = pop_link.job.op;
               if (full_mod) begin
                  r_in     = amt_w;
                  state_in = STATE_APPLY;
               end else begin
                  rem_start = 1'b1;
                  state_in  = STATE_AMT;
               end
            end
         end
         STATE_AMT: begin
            if (rem_done) begin
               r_in = rem_result;
               if (dirty_ff) begin
                  rem_start = 1'b1;
                  rem_value = count_ff;
                  state_in  = STATE_CNT;
               end else begin
                  state_in = STATE_APPLY;
               end
            end
         end
         STATE_CNT: begin
            if (rem_done) begin
               count_in = rem_result;
               state_in = STATE_APPLY;
            end
         end
         STATE_APPLY: begin
            if (out_free) begin
               count_in     = new_count;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RESULT_WIDTH'(new_count);
               dirty_in     = 1'b0;
               state_in     = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase

      // count may sit above a lowered top until reduced
      if (csr_wr_en) begin
         top_in   = csr_wr_data;
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         top_ff       <= '1;
         dirty_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         dirty_ff     <= dirty_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/mwc_checker.sv =====
module mwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_wr_en,
   input logic [31:0] csr_wr_data
);

   logic [3:0]  open_ff, open_in;
   logic [31:0] top_ff;
   logic        req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
         top_ff  <= '1;
      end else begin
         open_ff <= open_in;
         if (csr_wr_en) begin
            top_ff <= csr_wr_data;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 4'd0)
      else $error("result word without an open request");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= top_ff)
      else $error("count above top_value");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 4'd4)
      else $error("more words in flight than the block can hold");

endmodule

bind modular_wrap_counter mwc_checker u_mwc_checker (.*);
